// ----- rtl/apl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_pkg
// Shared types and codes for the APL scalar integer ALU.
// ----------------------------------------------------------------------------
package apl_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = DATA_W / 2;
    localparam int OP_W   = 5;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_IDENT = 5'd0,
        OP_NEG   = 5'd1,
        OP_SIGN  = 5'd2,
        OP_RECIP = 5'd3,
        OP_ABS   = 5'd4,
        OP_ADD   = 5'd5,
        OP_SUB   = 5'd6,
        OP_MUL   = 5'd7,
        OP_DIV   = 5'd8,
        OP_REM   = 5'd9,
        OP_MAX   = 5'd10,
        OP_MIN   = 5'd11,
        OP_LT    = 5'd12,
        OP_LE    = 5'd13,
        OP_EQ    = 5'd14,
        OP_NE    = 5'd15,
        OP_GE    = 5'd16,
        OP_GT    = 5'd17
    } op_t;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_DOMAIN  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;

    // Sideband that rides along the divider chain.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              a_neg;
        logic              b_neg;
        logic [ST_W-1:0]   status;
        logic              last;
        logic [DATA_W-1:0] val;     // result of the ops other than mul, div and rem
        logic [DATA_W-1:0] pp_lo;   // a_lo * b_lo
        logic [HALF_W-1:0] pp_ab;   // low half of a_lo * b_hi
        logic [HALF_W-1:0] pp_ba;   // low half of a_hi * b_lo
    } item_t;

    // Restoring-divider working state.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] nq;      // dividend bits out, quotient bits in
        logic [DATA_W-1:0] den;
    } div_t;

endpackage

// ----- rtl/apl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_front
// Decode, non-mul/div/rem ops, multiplier partial products, divider setup.
// ----------------------------------------------------------------------------
module apl_front
    import apl_pkg::*;
(
    input  logic [OP_W-1:0]   action,
    input  logic [DATA_W-1:0] left_operand,
    input  logic [DATA_W-1:0] right_operand,
    input  logic              last_in,
    output item_t             item,
    output div_t              div
);

    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              a_neg;
    logic              b_neg;
    logic              lt_ab;
    logic              lt_ba;
    logic              b_zero;
    logic [DATA_W-1:0] v;
    logic [ST_W-1:0]   st;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [HALF_W-1:0] prod_ab;
    logic [HALF_W-1:0] prod_ba;

    assign a      = left_operand;
    assign b      = right_operand;
    assign a_neg  = a[DATA_W-1];
    assign b_neg  = b[DATA_W-1];
    assign lt_ab  = $signed(a) < $signed(b);
    assign lt_ba  = $signed(b) < $signed(a);
    assign b_zero = (b == '0);
    assign mag_a  = a_neg ? (~a + 1'b1) : a;
    assign mag_b  = b_neg ? (~b + 1'b1) : b;

    always_comb
    begin
        v  = '0;
        st = ST_OK;
        case (action)
            OP_IDENT: v = b;
            OP_NEG:   v = ~b + 1'b1;
            OP_SIGN:  v = b_zero ? '0 : (b_neg ? '1 : DATA_W'(1));
            OP_RECIP:
            begin
                if (b_zero)
                    st = ST_DOMAIN;
                else if (b == DATA_W'(1))
                    v = DATA_W'(1);
                else if (b == '1)
                    v = '1;
            end
            OP_ABS:   v = mag_b;
            OP_ADD:   v = a + b;
            OP_SUB:   v = a - b;
            OP_MUL:   v = '0;
            OP_DIV, OP_REM:
            begin
                if (b_zero)
                    st = ST_DOMAIN;
            end
            OP_MAX:   v = lt_ab ? b : a;
            OP_MIN:   v = lt_ba ? b : a;
            OP_LT:    v = DATA_W'(lt_ab);
            OP_LE:    v = DATA_W'(!lt_ba);
            OP_EQ:    v = DATA_W'(a == b);
            OP_NE:    v = DATA_W'(a != b);
            OP_GE:    v = DATA_W'(!lt_ab);
            OP_GT:    v = DATA_W'(lt_ba);
            default:  st = ST_UNKNOWN;
        endcase
    end

    // Three 32x32 products; the low 64 bits of the full product follow.
    // Cross terms only feed the upper half, so only their low halves count.
    assign prod_ab = a[HALF_W-1:0] * b[DATA_W-1:HALF_W];
    assign prod_ba = a[DATA_W-1:HALF_W] * b[HALF_W-1:0];

    always_comb
    begin
        item.op     = action;
        item.a_neg  = a_neg;
        item.b_neg  = b_neg;
        item.status = st;
        item.last   = last_in;
        item.val    = v;
        item.pp_lo  = a[HALF_W-1:0] * b[HALF_W-1:0];
        item.pp_ab  = prod_ab;
        item.pp_ba  = prod_ba;
        div.rem     = '0;
        div.nq      = mag_a;
        div.den     = mag_b;
    end

endmodule

// ----- rtl/apl_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_div_cell
// One restoring-division step; registers one quotient bit and the sideband.
// ----------------------------------------------------------------------------
module apl_div_cell
    import apl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_vld,
    input  item_t in_item,
    input  div_t  in_div,
    output logic  out_vld,
    output item_t out_item,
    output div_t  out_div
);

    logic          vld_reg;
    item_t         item_reg;
    div_t          div_reg;
    div_t          div_next;
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic          ge;

    assign trial = {in_div.rem, in_div.nq[DATA_W-1]};
    assign diff  = trial - {1'b0, in_div.den};
    assign ge    = !diff[DATA_W];

    always_comb
    begin
        div_next.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        div_next.nq  = {in_div.nq[DATA_W-2:0], ge};
        div_next.den = in_div.den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= in_item;
            div_reg  <= div_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;
    assign out_div  = div_reg;

endmodule

// ----- rtl/apl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_back
// Final result select: product sum, quotient and remainder sign fix.
// ----------------------------------------------------------------------------
module apl_back
    import apl_pkg::*;
(
    input  item_t             item,
    input  div_t              div,
    output logic [DATA_W-1:0] value,
    output logic [ST_W-1:0]   status,
    output logic              last
);

    logic [HALF_W-1:0] cross_sum;
    logic [DATA_W-1:0] v;

    assign cross_sum = item.pp_ab + item.pp_ba;

    always_comb
    begin
        case (item.op)
            OP_MUL:  v = item.pp_lo + {cross_sum, {HALF_W{1'b0}}};
            OP_DIV:  v = (item.a_neg ^ item.b_neg) ? (~div.nq + 1'b1) : div.nq;
            OP_REM:  v = item.a_neg ? (~div.rem + 1'b1) : div.rem;
            default: v = item.val;
        endcase
    end

    assign value  = (item.status == ST_OK) ? v : '0;
    assign status = item.status;
    assign last   = item.last;

endmodule

// ----- rtl/apl_scalar_integer_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_scalar_integer_alu
// 64-bit signed element ALU for APL scalar primitives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries action, left_operand,
//   right_operand and last_in; output channel (out_valid / out_stall)
//   carries value, status and last_out. A transfer happens on a rising edge
//   with valid high and stall low.
//   Throughput: one transfer per cycle, sustained while the output is not
//   stalled, for any mix of ops. Path: the transfer edge loads the input
//   register, then the decode/multiply register, 64 divider cells (one
//   quotient bit each) and the output register follow. The 64-cell
//   divider chain sets the latency; every op walks the same chain so
//   results stay in order.
//   Stall: when out_valid is high and out_stall is high, the whole pipe
//   freezes and in_stall goes high; nothing is dropped or repeated.
//   Reset: clears all valid bits; no result is presented until one arrives.
//   Status: 0 ok, 1 divide by zero (recip, div, rem), 2 unknown code;
//   value is zero on any error; last_out always copies last_in.
// ----------------------------------------------------------------------------
module apl_scalar_integer_alu
    import apl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   action,
    input  logic [DATA_W-1:0] left_operand,
    input  logic [DATA_W-1:0] right_operand,
    input  logic              last_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] value,
    output logic [ST_W-1:0]   status,
    output logic              last_out
);

    // Global advance: whole pipe moves unless the output is held.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Input register stage.
    logic              s0_vld_reg;
    logic [OP_W-1:0]   s0_op_reg;
    logic [DATA_W-1:0] s0_a_reg;
    logic [DATA_W-1:0] s0_b_reg;
    logic              s0_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (adv)
            s0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_op_reg   <= action;
            s0_a_reg    <= left_operand;
            s0_b_reg    <= right_operand;
            s0_last_reg <= last_in;
        end
    end

    // Decode and partial products, registered.
    item_t front_item;
    div_t  front_div;
    logic  s1_vld_reg;
    item_t s1_item_reg;
    div_t  s1_div_reg;

    apl_front u_front (
        .action        (s0_op_reg),
        .left_operand  (s0_a_reg),
        .right_operand (s0_b_reg),
        .last_in       (s0_last_reg),
        .item          (front_item),
        .div           (front_div)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= s0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= front_item;
            s1_div_reg  <= front_div;
        end
    end

    // Divider chain: cell k produces quotient bit DATA_W-1-k.
    logic  chain_vld  [DATA_W+1];
    item_t chain_item [DATA_W+1];
    div_t  chain_div  [DATA_W+1];

    assign chain_vld[0]  = s1_vld_reg;
    assign chain_item[0] = s1_item_reg;
    assign chain_div[0]  = s1_div_reg;

    for (genvar k = 0; k < DATA_W; k++)
    begin : g_cell
        apl_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_vld   (chain_vld[k]),
            .in_item  (chain_item[k]),
            .in_div   (chain_div[k]),
            .out_vld  (chain_vld[k+1]),
            .out_item (chain_item[k+1]),
            .out_div  (chain_div[k+1])
        );
    end

    // Result select and output register.
    logic [DATA_W-1:0] back_value;
    logic [ST_W-1:0]   back_status;
    logic              back_last;
    logic              out_vld_reg;
    logic [DATA_W-1:0] value_reg;
    logic [ST_W-1:0]   status_reg;
    logic              last_reg;

    apl_back u_back (
        .item   (chain_item[DATA_W]),
        .div    (chain_div[DATA_W]),
        .value  (back_value),
        .status (back_status),
        .last   (back_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= chain_vld[DATA_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg  <= back_value;
            status_reg <= back_status;
            last_reg   <= back_last;
        end
    end

    assign out_valid = out_vld_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign last_out  = last_reg;

endmodule

// ----- rtl/apl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_checker
// Port-level checks for the scalar ALU, bound to the top level.
// ----------------------------------------------------------------------------
module apl_checker
    import apl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [OP_W-1:0]   action,
    input logic [DATA_W-1:0] left_operand,
    input logic [DATA_W-1:0] right_operand,
    input logic              last_in,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DATA_W-1:0] value,
    input logic [ST_W-1:0]   status,
    input logic              last_out
);

    // Held result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(value) && $stable(status)
            && $stable(last_out)))
        else $error("stalled result changed");

    // Stalled input transfer stays put.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(action)
            && $stable(left_operand) && $stable(right_operand) && $stable(last_in)))
        else $error("stalled input changed");

    // Backpressure reaches the input.
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output held");

    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_UNKNOWN))
        else $error("bad status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (value == '0))
        else $error("nonzero value on error");

endmodule

bind apl_scalar_integer_alu apl_checker u_apl_checker (.*);

// ----- verif/tb_apl_scalar_integer_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_apl_scalar_integer_alu
// Self-checking bench for the 64-bit APL scalar ALU: directed corner items,
// then random streams under several idle/stall mixes, each result checked
// in order against a behavioral predictor.
// ----------------------------------------------------------------------------

class alu_scoreboard;
    typedef struct {
        logic [63:0] value;
        logic [1:0]  status;
        logic        last;
    } alu_result_t;

    alu_result_t pending[$];
    int          errors;
    int          checked;

    // Behavioral model of one element operation.
    function void note_input(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                             logic last);
        alu_result_t r;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        sa = a;
        sb = b;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        r.value  = '0;
        r.status = apl_pkg::ST_OK;
        r.last   = last;
        case (op)
            apl_pkg::OP_IDENT: r.value = b;
            apl_pkg::OP_NEG:   r.value = -b;
            apl_pkg::OP_SIGN:  r.value = (b == 0) ? 64'd0 : (b[63] ? '1 : 64'd1);
            apl_pkg::OP_RECIP:
                if (b == 0) r.status = apl_pkg::ST_DOMAIN;
                else if (b == 64'd1) r.value = 64'd1;
                else if (b == '1) r.value = '1;
            apl_pkg::OP_ABS:   r.value = mb;
            apl_pkg::OP_ADD:   r.value = a + b;
            apl_pkg::OP_SUB:   r.value = a - b;
            apl_pkg::OP_MUL:   r.value = a * b;
            apl_pkg::OP_DIV:
                if (b == 0) r.status = apl_pkg::ST_DOMAIN;
                else
                begin
                    q = ma / mb;
                    r.value = (a[63] != b[63]) ? -q : q;
                end
            apl_pkg::OP_REM:
                if (b == 0) r.status = apl_pkg::ST_DOMAIN;
                else
                begin
                    q = ma % mb;
                    r.value = a[63] ? -q : q;
                end
            apl_pkg::OP_MAX:   r.value = (sa < sb) ? b : a;
            apl_pkg::OP_MIN:   r.value = (sb < sa) ? b : a;
            apl_pkg::OP_LT:    r.value = {63'd0, sa < sb};
            apl_pkg::OP_LE:    r.value = {63'd0, sa <= sb};
            apl_pkg::OP_EQ:    r.value = {63'd0, a == b};
            apl_pkg::OP_NE:    r.value = {63'd0, a != b};
            apl_pkg::OP_GE:    r.value = {63'd0, sa >= sb};
            apl_pkg::OP_GT:    r.value = {63'd0, sa > sb};
            default:           r.status = apl_pkg::ST_UNKNOWN;
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] v, logic [1:0] s, logic l);
        alu_result_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result value=%h status=%0d last=%0b",
                     $time, v, s, l);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (v !== e.value)
        begin
            $display("%0t: value expected %h actual %h", $time, e.value, v);
            errors++;
        end
        if (s !== e.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, s);
            errors++;
        end
        if (l !== e.last)
        begin
            $display("%0t: last_out expected %0b actual %0b", $time, e.last, l);
            errors++;
        end
    endfunction
endclass

module tb_apl_scalar_integer_alu;
    import apl_pkg::*;

    localparam int LATENCY = 67;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [OP_W-1:0]   action;
    logic [DATA_W-1:0] left_operand;
    logic [DATA_W-1:0] right_operand;
    logic              last_in;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] value;
    logic [ST_W-1:0]   status;
    logic              last_out;

    // Idle/stall odds in percent, changed per phase by the stimulus process.
    int send_idle_pct;
    int recv_stall_pct;
    // Long receiver hold-off, counted down in the stall process.
    int hold_cycles;
    int sent;

    alu_scoreboard sb;

    apl_scalar_integer_alu dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .left_operand  (left_operand),
        .right_operand (right_operand),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value         (value),
        .status        (status),
        .last_out      (last_out)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Receiver side: random stall, or a forced long hold-off.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check on every output transfer; values sampled at the edge, before
    // the nonblocking updates of this step land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(value, status, last_out);
    end

    // Corner and random operand values used by the random items.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(9))
            0: return MIN64;
            1: return MAX64;
            2: return 64'd0;
            3: return 64'd1;
            4: return '1;
            5: return {{56{1'b0}}, 8'($urandom)} - 64'd128;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one item and hold it until the transfer happens.
    task automatic send_item(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                             logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= op;
        left_operand  <= a;
        right_operand <= b;
        last_in       <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(op, a, b, last);
        sent++;
    endtask

    task automatic send_random(int count);
        logic [4:0] op;
        for (int i = 0; i < count; i++)
        begin
            // Mostly legal codes; a few unknown ones.
            op = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 18))
                                          : 5'($urandom_range(17));
            send_item(op, pick_operand(), pick_operand(), 1'($urandom));
        end
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = '0;
        left_operand   = '0;
        right_operand  = '0;
        last_in        = 1'b0;
        out_stall      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        sent           = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: wrap cases, zero divisors, reciprocal, every code.
        send_item(OP_NEG,   '0,    MIN64, 1'b0);
        send_item(OP_ABS,   '0,    MIN64, 1'b1);
        send_item(OP_DIV,   MIN64, '1,    1'b0);
        send_item(OP_REM,   MIN64, '1,    1'b1);
        send_item(OP_RECIP, '1,    64'd0, 1'b1);
        send_item(OP_DIV,   MAX64, 64'd0, 1'b0);
        send_item(OP_REM,   MIN64, 64'd0, 1'b1);
        send_item(OP_RECIP, '0,    64'd1, 1'b0);
        send_item(OP_RECIP, '0,    '1,    1'b0);
        send_item(OP_RECIP, '0,    64'd7, 1'b0);
        send_item(OP_ADD,   MAX64, 64'd1, 1'b0);
        send_item(OP_SUB,   MIN64, 64'd1, 1'b0);
        send_item(OP_MUL,   MAX64, MAX64, 1'b1);
        send_item(OP_REM,   -64'sd7, 64'd2, 1'b0);
        send_item(5'd18,    MAX64, MAX64, 1'b1);
        send_item(5'd31,    '1,    '1,    1'b0);
        for (int op = 0; op <= 17; op++)
            send_item(5'(op), MIN64, MAX64, 1'($urandom));

        // No idling.
        send_random(300);
        // Sender idle.
        send_idle_pct = 54;
        send_random(250);
        // Receiver stalling, with one long hold-off so the pipe fills up.
        send_idle_pct  = 0;
        recv_stall_pct = 54;
        hold_cycles    = 200;
        send_random(300);
        // Both.
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        send_random(300);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(150);
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d items over all codes and operand corners, %0d results checked.",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("apl_scalar_integer_alu: match");
        else
            $display("apl_scalar_integer_alu: mismatch");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("apl_scalar_integer_alu: mismatch");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/apl_pkg.sv
rtl/apl_front.sv
rtl/apl_div_cell.sv
rtl/apl_back.sv
rtl/apl_scalar_integer_alu.sv
rtl/apl_checker.sv
verif/tb_apl_scalar_integer_alu.sv
